/* design/contiguous_page_allocator_defines.svh */
// Assertion macros for the contiguous page allocator
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPA_ASSERT_NOW(label, ante, cons, msg)
`define CPA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/cpa_pkg.sv */
// Shared types and constants for the contiguous page allocator
package cpa_pkg;

    localparam int PAGE_SLOTS_DEF = 1024;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int ADDR_W         = 64;
    localparam int COUNT_W        = 11;
    localparam int NUM_PAGES_RST  = 1024;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SPACE    = 3'd1,
        ST_ZERO_COUNT  = 3'd2,
        ST_BAD_ADDRESS = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } t_status;

    typedef enum logic {
        CFG_ALLOC_BASE = 1'b0,
        CFG_NUM_PAGES  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic last;
        logic taken;
    } t_flags;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  address;
    } t_resp;

endpackage

/* design/cpa_flag_mem.sv */
// Page flag table: one write port, one registered read port
module cpa_flag_mem
    import cpa_pkg::*;
#(
    parameter int DEPTH = PAGE_SLOTS_DEF,
    parameter int AW    = $clog2(PAGE_SLOTS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_flags        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_flags        o_rdata
);

    t_flags r_mem [DEPTH];
    t_flags r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/cpa_ctrl.sv */
// Request sequencer: first-fit scan, mark pass, free walk and clearing pass
module cpa_ctrl
    import cpa_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int AW         = $clog2(PAGE_SLOTS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_vld,
    output logic               o_req_rdy,
    input  t_op                i_op,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [ADDR_W-1:0]  i_faddr,
    input  logic [ADDR_W-1:0]  i_alloc_base,
    input  logic [COUNT_W-1:0] i_num_pages,
    output logic               o_resp_vld,
    input  logic               i_resp_rdy,
    output t_resp              o_resp,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output t_flags             o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  t_flags             i_mem_rdata
);

    localparam int CNT_W = $clog2(PAGE_SLOTS + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    t_state             r_state,   n_state;
    t_op                r_op,      n_op;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic [ADDR_W-1:0]  r_faddr,   n_faddr;
    logic [CW-1:0]      r_scan,    n_scan;
    logic               r_chk_vld, n_chk_vld;
    logic [CW-1:0]      r_chk_idx, n_chk_idx;
    logic [CW-1:0]      r_run,     n_run;
    logic [CW-1:0]      r_start,   n_start;
    t_status            r_status,  n_status;
    logic [ADDR_W-1:0]  r_addr,    n_addr;

    logic [CW-1:0]      w_usable;
    logic [CW-1:0]      w_count;
    logic [ADDR_W-1:0]  w_diff;
    logic [ADDR_W-1:0]  w_idx;
    logic               w_issue;

    assign w_count  = CW'(r_count);
    assign w_usable = (CW'(i_num_pages) > CW'(PAGE_SLOTS)) ? CW'(PAGE_SLOTS)
                                                           : CW'(i_num_pages);
    assign w_diff   = r_faddr - i_alloc_base;
    assign w_idx    = w_diff >> PAGE_SHIFT;
    assign w_issue  = (r_scan < w_usable);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_scan    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_count   <= n_count;
        r_faddr   <= n_faddr;
        r_chk_idx <= n_chk_idx;
        r_run     <= n_run;
        r_start   <= n_start;
        r_status  <= n_status;
        r_addr    <= n_addr;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_faddr     = r_faddr;
        n_scan      = r_scan;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_run       = r_run;
        n_start     = r_start;
        n_status    = r_status;
        n_addr      = r_addr;
        o_req_rdy   = 1'b0;
        o_resp_vld  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_chk_idx[AW-1:0];
        o_mem_wdata = '0;
        o_mem_raddr = r_scan[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_scan[AW-1:0];
                if (r_scan == CW'(PAGE_SLOTS - 1)) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_scan = r_scan + CW'(1);
                end
            end
            S_IDLE: begin
                o_req_rdy = 1'b1;
                if (i_req_vld) begin
                    n_op    = i_op;
                    n_count = i_count;
                    n_faddr = i_faddr;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_addr    = '0;
                n_chk_vld = 1'b0;
                n_run     = '0;
                if (r_op == OP_ALLOC) begin
                    n_scan = '0;
                    if (r_count == '0) begin
                        n_status = ST_ZERO_COUNT;
                        n_state  = S_RESP;
                    end else if (w_count > w_usable) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    if (w_idx >= ADDR_W'(w_usable)) begin
                        n_status = ST_BAD_ADDRESS;
                        n_state  = S_RESP;
                    end else begin
                        n_scan  = w_idx[CW-1:0];
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // read runs one page ahead of the check
                n_chk_vld = w_issue;
                n_chk_idx = r_scan;
                if (w_issue) begin
                    n_scan = r_scan + CW'(1);
                end
                if (r_chk_vld) begin
                    if (r_op == OP_ALLOC) begin
                        if (i_mem_rdata.taken) begin
                            n_run = '0;
                        end else begin
                            n_run = r_run + CW'(1);
                            if (r_run + CW'(1) == w_count) begin
                                n_start   = r_chk_idx + CW'(1) - w_count;
                                n_scan    = r_chk_idx + CW'(1) - w_count;
                                n_chk_idx = r_chk_idx;
                                n_chk_vld = 1'b0;
                                n_state   = S_MARK;
                            end
                        end
                    end else begin
                        if (i_mem_rdata.last) begin
                            o_mem_we  = 1'b1;
                            n_status  = ST_OK;
                            n_chk_vld = 1'b0;
                            n_state   = S_RESP;
                        end else if (!i_mem_rdata.taken) begin
                            n_status  = ST_DOUBLE_FREE;
                            n_chk_vld = 1'b0;
                            n_state   = S_RESP;
                        end else begin
                            o_mem_we = 1'b1;
                        end
                    end
                end else if (!w_issue) begin
                    // walked off the usable range
                    n_status = (r_op == OP_ALLOC) ? ST_NO_SPACE : ST_DOUBLE_FREE;
                    n_state  = S_RESP;
                end
            end
            S_MARK: begin
                o_mem_we          = 1'b1;
                o_mem_waddr       = r_scan[AW-1:0];
                o_mem_wdata.taken = 1'b1;
                o_mem_wdata.last  = (r_scan == r_chk_idx);
                n_scan            = r_scan + CW'(1);
                if (r_scan == r_chk_idx) begin
                    n_status = ST_OK;
                    n_addr   = i_alloc_base + (ADDR_W'(r_start) << PAGE_SHIFT);
                    n_state  = S_RESP;
                end
            end
            S_RESP: begin
                o_resp_vld = 1'b1;
                if (i_resp_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_scan  = '0;
            end
        endcase
    end

    assign o_resp.status  = r_status;
    assign o_resp.address = r_addr;

endmodule

/* design/contiguous_page_allocator.sv */
// Allocate: decode, first-fit scan, then a mark pass over the n pages on success.
// Free: decode, then a clearing walk; requests rejected at decode skip the scan.
// One request at a time; the single flag-table read port walks one page a cycle.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-low reset starts a clearing pass over every slot of the flag
// table; no request is taken until it ends. Config: base 0, 1024 pages.
module contiguous_page_allocator
    import cpa_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [79:0]        s_axis_tdata,  // page_count[10:0], free_address[74:11]
    input  logic               s_axis_tuser,  // opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ADDR_W-1:0]  m_axis_tdata,  // address[63:0]
    output logic [2:0]         m_axis_tuser   // status
);

    localparam int AW = $clog2(PAGE_SLOTS);

    logic [ADDR_W-1:0]  r_alloc_base;
    logic [COUNT_W-1:0] r_num_pages;
    logic               r_out_vld;
    t_resp              r_out;

    logic               w_resp_vld;
    logic               w_resp_rdy;
    t_resp              w_resp;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    t_flags             w_mem_wdata;
    logic [AW-1:0]      w_mem_raddr;
    t_flags             w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_base <= '0;
            r_num_pages  <= COUNT_W'(NUM_PAGES_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_ALLOC_BASE: r_alloc_base <= i_cfg_data;
                CFG_NUM_PAGES:  r_num_pages  <= i_cfg_data[COUNT_W-1:0];
                default:        r_num_pages  <= r_num_pages;
            endcase
        end
    end

    assign w_resp_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_resp_vld && w_resp_rdy) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_resp_vld && w_resp_rdy) begin
            r_out <= w_resp;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out.address;
    assign m_axis_tuser  = r_out.status;

    cpa_ctrl #(
        .PAGE_SLOTS (PAGE_SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_vld    (s_axis_tvalid),
        .o_req_rdy    (s_axis_tready),
        .i_op         (t_op'(s_axis_tuser)),
        .i_count      (s_axis_tdata[COUNT_W-1:0]),
        .i_faddr      (s_axis_tdata[COUNT_W +: ADDR_W]),
        .i_alloc_base (r_alloc_base),
        .i_num_pages  (r_num_pages),
        .o_resp_vld   (w_resp_vld),
        .i_resp_rdy   (w_resp_rdy),
        .o_resp       (w_resp),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    cpa_flag_mem #(
        .DEPTH (PAGE_SLOTS),
        .AW    (AW)
    ) u_flag_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

`include "contiguous_page_allocator_defines.svh"

    `CPA_ASSERT_NEXT(a_resp_held, w_resp_vld && !w_resp_rdy, w_resp_vld, "result dropped while output busy")
    `CPA_ASSERT_NOW(a_no_accept_pending, w_resp_vld, !s_axis_tready, "request taken with result pending")
    `CPA_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
    `CPA_ASSERT_NOW(a_fail_addr_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "non-zero address on failure")

endmodule

/* verif/page_alloc_checker.sv */
// Checker for the page allocator: predicts each request's result and compares it
`timescale 1ns / 1ps

module page_alloc_checker
    import cpa_pkg::*;
#(
    parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [79:0]       i_req_data,   // page_count[10:0], free_address[74:11]
    input  logic              i_req_user,   // opcode
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  logic [ADDR_W-1:0] i_rsp_data,   // address[63:0]
    input  logic [2:0]        i_rsp_user,   // status
    output int                o_pending,
    output int                o_fail_count
);

    localparam int MAX_REPORTS = 30;

    t_flags              page_tbl [PAGE_SLOTS];
    logic [ADDR_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  pages_reg;
    t_resp               expected_results [$];
    int                  fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what);
        if (fails < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    // First-fit allocate or walk-and-clear free against the local flag table
    task automatic predict_request(input t_op op, input logic [COUNT_W-1:0] cnt,
                                   input logic [ADDR_W-1:0] addr, output t_resp res);
        int unsigned       np;
        int unsigned       run;
        int                i;
        int                k;
        int                start;
        int                idx;
        logic [ADDR_W-1:0] page_off;
        bit                done;
        np = (pages_reg > PAGE_SLOTS) ? PAGE_SLOTS : pages_reg;
        res.address = '0;
        if (op == OP_ALLOC) begin
            if (cnt == 0) begin
                res.status = ST_ZERO_COUNT;
            end else if (cnt > np) begin
                res.status = ST_NO_SPACE;
            end else begin
                res.status = ST_NO_SPACE;
                run = 0;
                for (i = 0; i < int'(np); i++) begin
                    if (page_tbl[i].taken) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == cnt) begin
                            start = i + 1 - int'(cnt);
                            for (k = start; k <= i; k++)
                                page_tbl[k] = '{last: 1'b0, taken: 1'b1};
                            page_tbl[i].last = 1'b1;
                            res.address = base_reg + (64'(start) << PAGE_SHIFT);
                            res.status  = ST_OK;
                            break;
                        end
                    end
                end
            end
        end else begin
            page_off = (addr - base_reg) >> PAGE_SHIFT;
            if (page_off >= 64'(np)) begin
                res.status = ST_BAD_ADDRESS;
            end else begin
                // running off the end of the usable pages also counts as a double free
                res.status = ST_DOUBLE_FREE;
                idx  = int'(page_off);
                done = 1'b0;
                while (idx < int'(np) && !done) begin
                    if (page_tbl[idx].last) begin
                        page_tbl[idx] = '0;
                        res.status    = ST_OK;
                        done          = 1'b1;
                    end else if (!page_tbl[idx].taken) begin
                        done = 1'b1;
                    end else begin
                        page_tbl[idx] = '0;
                        idx++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_resp want;
        t_resp got;
        if (!i_rst_n) begin
            for (int j = 0; j < PAGE_SLOTS; j++)
                page_tbl[j] = '0;
            base_reg  = '0;
            pages_reg = COUNT_W'(NUM_PAGES_RST);
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_reg'(i_cfg_idx) == CFG_ALLOC_BASE)
                    base_reg = i_cfg_data;
                else
                    pages_reg = i_cfg_data[COUNT_W-1:0];
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d address %h with none pending",
                                              i_rsp_user, i_rsp_data));
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp_user !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp_user, want.status));
                    if (i_rsp_data !== want.address)
                        report_mismatch($sformatf("address %h, expected %h",
                                                  i_rsp_data, want.address));
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(t_op'(i_req_user), i_req_data[COUNT_W-1:0],
                                i_req_data[COUNT_W +: ADDR_W], got);
                expected_results.push_back(got);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

/* verif/testbench.sv */
// Testbench top: request stimulus, result sink and verdict for the page allocator
`timescale 1ns / 1ps

module testbench;
    import cpa_pkg::*;

    localparam int                PAGE_SLOTS   = PAGE_SLOTS_DEF;
    localparam int                PAGE_SHIFT   = PAGE_SHIFT_DEF;
    localparam logic [ADDR_W-1:0] PAGE_BYTES   = 64'd1 << PAGE_SHIFT;
    localparam int                N_PHASES     = 7;
    localparam int                SETTLE       = 16;
    localparam int                LONG_HOLD_AT = 150;
    localparam int                LONG_HOLD    = 400;

    logic               i_clk    = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic               cfg_idx  = 1'b0;
    logic [ADDR_W-1:0]  cfg_data = '0;
    logic               s_valid  = 1'b0;
    logic [79:0]        s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_ready  = 1'b0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [ADDR_W-1:0]  m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    int                 pending;
    int                 fails;

    t_op                sent_ops    [$];
    logic [ADDR_W-1:0]  live_allocs [$];
    logic [ADDR_W-1:0]  freed_addrs [$];
    int                 n_sent    = 0;
    int                 n_results = 0;

    contiguous_page_allocator #(
        .PAGE_SLOTS (PAGE_SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_alloc_checker #(
        .PAGE_SLOTS (PAGE_SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_tdata),
        .i_req_user   (s_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_ready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(100_000_000);
        $display("testbench failed");
        $finish;
    end

    // Result sink: random back-pressure, one long hold, and tracking of live allocations
    initial begin : result_sink
        int  gap;
        t_op op;
        forever begin
            @(posedge i_clk);
            gap = 0;
            if (m_ready && m_axis_tvalid) begin
                if (sent_ops.size() != 0) begin
                    op = sent_ops.pop_front();
                    if (op == OP_ALLOC && m_axis_tuser == ST_OK)
                        live_allocs.push_back(m_axis_tdata);
                end
                n_results++;
                if (n_results == LONG_HOLD_AT)
                    gap = LONG_HOLD;
                else if (((n_results / 40) % 5) != 4)
                    gap = $urandom_range(0, 4);
            end else if (!m_ready) begin
                m_ready <= 1'b1;
            end else if (!m_axis_tvalid && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 4);
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input t_op op, input logic [COUNT_W-1:0] cnt,
                                input logic [ADDR_W-1:0] addr);
        int gap;
        gap = (((n_sent / 40) % 5) == 4) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, addr, cnt};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sent_ops.push_back(op);
        n_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Free whatever is still live, then let the block go quiet
    task automatic close_phase();
        wait_all_results();
        while (live_allocs.size() != 0)
            send_request(OP_FREE, COUNT_W'($urandom), live_allocs.pop_front());
        wait_all_results();
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0]  cur_base;
        logic [COUNT_W-1:0] cur_pages;
        int unsigned        usable;
        int                 n_rand;
        int                 r;
        int                 pick;
        logic [ADDR_W-1:0]  a;
        logic [COUNT_W-1:0] cnt;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin cur_base = '0; cur_pages = 11'd1024; n_rand = 0; end
                1: begin cur_base = '0; cur_pages = 11'd1; n_rand = 40; end
                2: begin cur_base = 64'hFFFF_FFFF_FFF0_0000; cur_pages = 11'd1024; n_rand = 100; end
                3: begin cur_base = rand_addr() & ~(PAGE_BYTES - 1); cur_pages = 11'h7FF;
                         n_rand = 100; end
                4: begin cur_base = rand_addr(); cur_pages = 11'd0; n_rand = 30; end
                5: begin cur_base = '1; cur_pages = COUNT_W'($urandom_range(2, 64));
                         n_rand = 100; end
                default: begin cur_base = rand_addr() & ~(PAGE_BYTES - 1);
                         cur_pages = 11'd1024; n_rand = 180; end
            endcase
            usable = (cur_pages > PAGE_SLOTS) ? PAGE_SLOTS : cur_pages;

            if (p != 0) begin
                close_phase();
                cfg_we   <= 1'b1;
                cfg_idx  <= CFG_NUM_PAGES;
                cfg_data <= {$urandom, 21'(0), cur_pages} ;
                @(posedge i_clk);
                cfg_idx  <= CFG_ALLOC_BASE;
                cfg_data <= cur_base;
                @(posedge i_clk);
                cfg_we   <= 1'b0;
                @(posedge i_clk);
            end

            if (p == 0) begin
                // whole table, then a full failed scan, then one long free walk
                send_request(OP_ALLOC, 11'd1024, '0);
                send_request(OP_ALLOC, 11'd1, '1);
                send_request(OP_FREE, 11'h7FF, 64'h0);
                send_request(OP_ALLOC, 11'd0, '1);
                send_request(OP_ALLOC, 11'h7FF, rand_addr());
                send_request(OP_ALLOC, 11'd3, rand_addr());
                send_request(OP_ALLOC, 11'd2, rand_addr());
                // free from the middle of an allocation, then from its head
                send_request(OP_FREE, 11'd0, 64'h1000);
                send_request(OP_FREE, 11'h7FF, 64'h0FFF);
                send_request(OP_FREE, 11'd0, 64'h3FFF);
                send_request(OP_FREE, 11'd0, 64'h3000);
                send_request(OP_FREE, 11'h7FF, '1);
                send_request(OP_FREE, 11'd0, 64'h0040_0000);
                send_request(OP_FREE, 11'd0, 64'h003F_F000);
                wait_all_results();
                live_allocs.delete();
                // leaves page 0 taken without last once the count drops to one
                send_request(OP_ALLOC, 11'd2, '0);
                wait_all_results();
                live_allocs.delete();
            end else if (p == 1) begin
                send_request(OP_FREE, 11'd0, 64'h0);
                send_request(OP_FREE, 11'd0, PAGE_BYTES);
                send_request(OP_ALLOC, 11'd2, '0);
                send_request(OP_ALLOC, 11'd1, '0);
                send_request(OP_ALLOC, 11'd1, '0);
            end

            for (int it = 0; it < n_rand; it++) begin
                r = $urandom_range(0, 99);
                if (r < 45 && live_allocs.size() != 0) begin
                    pick = $urandom_range(0, live_allocs.size() - 1);
                    a = live_allocs[pick];
                    live_allocs.delete(pick);
                    freed_addrs.push_back(a);
                    if (freed_addrs.size() > 8)
                        void'(freed_addrs.pop_front());
                    if ($urandom_range(0, 9) < 3)
                        a = a + 64'($urandom_range(0, PAGE_BYTES - 1));
                    send_request(OP_FREE, COUNT_W'($urandom), a);
                end else if (r < 88) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        cnt = '0;
                    else if (pick < 88)
                        cnt = COUNT_W'($urandom_range(1, 8));
                    else if (pick < 96)
                        cnt = COUNT_W'($urandom_range(1, (usable == 0) ? 1 : usable));
                    else
                        cnt = COUNT_W'($urandom_range(0, 2047));
                    send_request(OP_ALLOC, cnt, rand_addr());
                end else begin
                    // stale, wild, below-base and addresses in or just past the usable range
                    case ($urandom_range(0, 3))
                        0: a = (freed_addrs.size() != 0)
                               ? freed_addrs[$urandom_range(0, freed_addrs.size() - 1)]
                               : rand_addr();
                        1: a = rand_addr();
                        2: a = cur_base - 64'($urandom_range(1, 1 << 20));
                        default: a = cur_base
                                     + (64'($urandom_range(0, usable + 2)) << PAGE_SHIFT)
                                     + 64'($urandom_range(0, PAGE_BYTES - 1));
                    endcase
                    send_request(OP_FREE, COUNT_W'($urandom), a);
                end
            end
        end

        close_phase();
        repeat (64) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/cpa_pkg.sv
design/cpa_flag_mem.sv
design/cpa_ctrl.sv
design/contiguous_page_allocator.sv
verif/page_alloc_checker.sv
verif/testbench.sv
